// ===== hdl/spq_pkg.sv =====
// Shared types, sizes and codes for the sorted priority queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;
	localparam int PRI_BITS = 32;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		FUNC_ENQ   = 2'd0,
		FUNC_DEQ   = 2'd1,
		FUNC_CHG   = 2'd2,
		FUNC_CLEAR = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REINS,
		ST_DONE
	} state_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic                       ins;
		logic                       rem;
		logic                       rem_head;
		logic [KEY_BITS-1:0]        key;
		logic signed [PRI_BITS-1:0] pri;
	} chain_op_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds a key and priority, trades with its neighbors.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic                       clk,
	input  wire chain_op_t                  op,
	input  wire logic                       valid,
	input  wire logic [KEY_BITS-1:0]        left_key,
	input  wire logic signed [PRI_BITS-1:0] left_pri,
	input  wire logic                       left_before,
	input  wire logic [KEY_BITS-1:0]        right_key,
	input  wire logic signed [PRI_BITS-1:0] right_pri,
	input  wire logic                       seen_in,
	output logic [KEY_BITS-1:0]             key,
	output logic signed [PRI_BITS-1:0]      pri,
	output logic                            ahead,
	output logic                            seen_out
);

	logic [KEY_BITS-1:0]        key_q;
	logic signed [PRI_BITS-1:0] pri_q;
	logic                       match;
	logic                       take_left;
	logic                       take_new;
	logic                       take_right;

	// New entry belongs at or ahead of this slot (empty slots always qualify).
	assign ahead = !valid || (pri_q > op.pri) || (pri_q == op.pri && op.key <= key_q);

	assign match    = valid && (key_q == op.key);
	assign seen_out = seen_in || match;

	assign take_left  = op.ins && ahead && left_before;
	assign take_new   = op.ins && ahead && !left_before;
	// Removal: dequeue shifts everything, change shifts from the first match on.
	assign take_right = op.rem && (op.rem_head || seen_in || match);

	always_ff @(posedge clk) begin
		priority if (take_left) begin
			key_q <= left_key;
			pri_q <= left_pri;
		end else if (take_new) begin
			key_q <= op.key;
			pri_q <= op.pri;
		end else if (take_right) begin
			key_q <= right_key;
			pri_q <= right_pri;
		end
	end

	assign key = key_q;
	assign pri = pri_q;

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: request control, occupancy and result register.
// Depends on spq_pkg and spq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of DEPTH entries held in ascending (priority, key) order in a
// row of cells, the head in cell 0. An enqueue, dequeue or clear updates the whole row on
// the edge it is accepted; the request then passes through ST_DONE and the registered
// out_valid. A change priority that finds its key also passes ST_REINS, removing the
// entry on the accepting edge and inserting it again from ST_REINS. One request is in
// flight at a time; the next one is taken as soon as the previous result is taken, or on
// the same edge, so no new request goes in before the last one's result is out. Each
// request gives one result describing the queue afterwards; an empty queue reports a
// zero head.
module sorted_priority_queue
	import spq_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 func,
	input  wire logic [KEY_BITS-1:0]        item_key,
	input  wire logic signed [PRI_BITS-1:0] item_priority,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [KEY_BITS-1:0]             taken_key,
	output logic [KEY_BITS-1:0]             head_key,
	output logic signed [PRI_BITS-1:0]      head_priority,
	output logic                            is_empty,
	output logic [CNT_BITS-1:0]             entry_count,
	output logic [1:0]                      status
);

	state_t                     state_q, state_d;
	logic [CNT_BITS-1:0]        count_q;
	logic                       out_valid_q;
	logic [KEY_BITS-1:0]        key_q;
	logic signed [PRI_BITS-1:0] pri_q;
	logic [KEY_BITS-1:0]        taken_q;
	status_t                    status_q;
	logic [KEY_BITS-1:0]        taken_key_q;
	logic [KEY_BITS-1:0]        head_key_q;
	logic signed [PRI_BITS-1:0] head_pri_q;
	logic                       is_empty_q;
	logic [CNT_BITS-1:0]        entry_count_q;
	status_t                    status_out_q;

	func_t     req_func;
	logic      accept;
	logic      q_empty;
	logic      q_full;
	logic      found;
	chain_op_t op;

	logic [KEY_BITS-1:0]        cell_key    [DEPTH];
	logic signed [PRI_BITS-1:0] cell_pri    [DEPTH];
	logic                       cell_before [DEPTH];
	logic                       cell_seen   [DEPTH];

	assign req_func = func_t'(func);
	assign accept   = in_valid && in_ready;
	assign q_empty  = (count_q == '0);
	assign q_full   = (count_q == CNT_BITS'(DEPTH));
	assign found    = cell_seen[DEPTH-1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_func == FUNC_CHG && !q_empty && found)
						state_d = ST_REINS;
					else
						state_d = ST_DONE;
				end
			end
			ST_REINS: state_d = ST_DONE;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs: ready and the operation driven into the chain
	always_comb begin
		in_ready    = 1'b0;
		op.ins      = 1'b0;
		op.rem      = 1'b0;
		op.rem_head = 1'b0;
		op.key      = item_key;
		op.pri      = item_priority;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = !out_valid_q || out_ready;
				op.ins      = in_valid && in_ready && req_func == FUNC_ENQ && !q_full;
				op.rem      = in_valid && in_ready && !q_empty &&
				              (req_func == FUNC_DEQ || req_func == FUNC_CHG);
				op.rem_head = req_func == FUNC_DEQ;
			end
			ST_REINS: begin
				op.ins = 1'b1;
				op.key = key_q;
				op.pri = pri_q;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                       valid;
		logic [KEY_BITS-1:0]        lkey;
		logic signed [PRI_BITS-1:0] lpri;
		logic                       lbefore;
		logic                       lseen;
		logic [KEY_BITS-1:0]        rkey;
		logic signed [PRI_BITS-1:0] rpri;

		assign valid = CNT_BITS'(i) < count_q;

		if (i == 0) begin : g_first
			assign lkey    = op.key;
			assign lpri    = op.pri;
			assign lbefore = 1'b0;
			assign lseen   = 1'b0;
		end else begin : g_mid
			assign lkey    = cell_key[i-1];
			assign lpri    = cell_pri[i-1];
			assign lbefore = cell_before[i-1];
			assign lseen   = cell_seen[i-1];
		end

		// last cell pulls its own contents; it falls out of range by the count drop
		if (i == DEPTH - 1) begin : g_last
			assign rkey = cell_key[i];
			assign rpri = cell_pri[i];
		end else begin : g_inner
			assign rkey = cell_key[i+1];
			assign rpri = cell_pri[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.op         (op),
			.valid      (valid),
			.left_key   (lkey),
			.left_pri   (lpri),
			.left_before(lbefore),
			.right_key  (rkey),
			.right_pri  (rpri),
			.seen_in    (lseen),
			.key        (cell_key[i]),
			.pri        (cell_pri[i]),
			.ahead      (cell_before[i]),
			.seen_out   (cell_seen[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (req_func)
					FUNC_ENQ:   if (!q_full) count_q <= count_q + 1'b1;
					FUNC_DEQ:   if (!q_empty) count_q <= count_q - 1'b1;
					FUNC_CHG:   if (!q_empty && found) count_q <= count_q - 1'b1;
					FUNC_CLEAR: count_q <= '0;
					default:    ;
				endcase
			end else if (state_q == ST_REINS) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == ST_DONE)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q    <= item_key;
			pri_q    <= item_priority;
			taken_q  <= '0;
			status_q <= STAT_OK;
			unique case (req_func)
				FUNC_ENQ: if (q_full) status_q <= STAT_FULL;
				FUNC_DEQ: begin
					if (q_empty)
						status_q <= STAT_EMPTY;
					else
						taken_q <= cell_key[0];
				end
				FUNC_CHG: begin
					if (q_empty)
						status_q <= STAT_EMPTY;
					else if (!found)
						status_q <= STAT_NOT_FOUND;
				end
				FUNC_CLEAR: ;
				default:    ;
			endcase
		end
		if (state_q == ST_DONE) begin
			taken_key_q   <= taken_q;
			head_key_q    <= q_empty ? '0 : cell_key[0];
			head_pri_q    <= q_empty ? '0 : cell_pri[0];
			is_empty_q    <= q_empty;
			entry_count_q <= count_q;
			status_out_q  <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign taken_key     = taken_key_q;
	assign head_key      = head_key_q;
	assign head_priority = head_pri_q;
	assign is_empty      = is_empty_q;
	assign entry_count   = entry_count_q;
	assign status        = status_out_q;

endmodule

`default_nettype wire

// ===== hdl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_assertions
	import spq_pkg::*;
(
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [KEY_BITS-1:0]        taken_key,
	input wire logic [KEY_BITS-1:0]        head_key,
	input wire logic signed [PRI_BITS-1:0] head_priority,
	input wire logic                       is_empty,
	input wire logic [CNT_BITS-1:0]        entry_count,
	input wire logic [1:0]                 status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(head_key) && $stable(taken_key)
		&& $stable(head_priority) && $stable(entry_count) && $stable(status))
		else $error("result changed while stalled");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_FULL |-> entry_count == CNT_BITS'(DEPTH))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STAT_EMPTY |-> is_empty && taken_key == '0)
		else $error("empty status on a nonempty queue");

endmodule

bind sorted_priority_queue spq_assertions u_spq_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.taken_key    (taken_key),
	.head_key     (head_key),
	.head_priority(head_priority),
	.is_empty     (is_empty),
	.entry_count  (entry_count),
	.status       (status)
);

`default_nettype wire

// ===== bench/spq_checker.sv =====
// Checker for the sorted priority queue: keeps its own sorted list of entries,
// predicts one result per accepted request and compares each returned result.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_checker
	import spq_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [KEY_BITS-1:0]        item_key,
	input  logic signed [PRI_BITS-1:0] item_priority,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [KEY_BITS-1:0]        taken_key,
	input  logic [KEY_BITS-1:0]        head_key,
	input  logic signed [PRI_BITS-1:0] head_priority,
	input  logic                       is_empty,
	input  logic [CNT_BITS-1:0]        entry_count,
	input  logic [1:0]                 status,
	output int                         fail_count,
	output int                         pending
);

	typedef struct {
		logic [KEY_BITS-1:0]        taken;
		logic [KEY_BITS-1:0]        head_key;
		logic signed [PRI_BITS-1:0] head_pri;
		logic                       empty;
		logic [CNT_BITS-1:0]        count;
		status_t                    stat;
	} queue_view_t;

	queue_view_t                expected_views[$];
	queue_view_t                want;
	logic [KEY_BITS-1:0]        order_key [DEPTH];
	logic signed [PRI_BITS-1:0] order_pri [DEPTH];
	int                         held;

	// ascending priority, then smaller key; a new entry goes ahead of an equal one
	function automatic void place_entry(input logic [KEY_BITS-1:0] k,
	                                    input logic signed [PRI_BITS-1:0] p);
		int pos;
		pos = 0;
		while (pos < held && !(order_pri[pos] > p || (order_pri[pos] == p && k <= order_key[pos])))
			pos++;
		for (int i = held; i > pos; i--) begin
			order_key[i] = order_key[i-1];
			order_pri[i] = order_pri[i-1];
		end
		order_key[pos] = k;
		order_pri[pos] = p;
		held++;
	endfunction

	function automatic void drop_entry(input int pos);
		for (int i = pos; i + 1 < held; i++) begin
			order_key[i] = order_key[i+1];
			order_pri[i] = order_pri[i+1];
		end
		held--;
	endfunction

	function automatic queue_view_t apply_request(input func_t f, input logic [KEY_BITS-1:0] k,
	                                              input logic signed [PRI_BITS-1:0] p);
		queue_view_t v;
		int          i;
		v.taken = '0;
		v.stat  = STAT_OK;
		case (f)
			FUNC_ENQ: begin
				if (held >= DEPTH)
					v.stat = STAT_FULL;
				else
					place_entry(k, p);
			end
			FUNC_DEQ: begin
				if (held == 0) begin
					v.stat = STAT_EMPTY;
				end else begin
					v.taken = order_key[0];
					drop_entry(0);
				end
			end
			FUNC_CHG: begin
				if (held == 0) begin
					v.stat = STAT_EMPTY;
				end else begin
					i = 0;
					while (i < held && order_key[i] != k)
						i++;
					if (i == held) begin
						v.stat = STAT_NOT_FOUND;
					end else begin
						// first match is moved, head included
						drop_entry(i);
						place_entry(k, p);
					end
				end
			end
			default: held = 0;
		endcase
		v.head_key = held != 0 ? order_key[0] : '0;
		v.head_pri = held != 0 ? order_pri[0] : '0;
		v.empty    = held == 0;
		v.count    = CNT_BITS'(held);
		return v;
	endfunction

	function automatic int field_bad(input string name, input logic [63:0] exp_val,
	                                 input logic [63:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, actual %0h", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			expected_views.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// a result can never belong to a request taken on the same edge
			if (out_valid && out_ready) begin
				if (expected_views.size() == 0) begin
					$error("result returned with no request outstanding");
					fail_count++;
				end else begin
					want = expected_views.pop_front();
					if (field_bad("taken_key", want.taken, taken_key)
					    + field_bad("head_key", want.head_key, head_key)
					    + field_bad("head_priority", $unsigned(want.head_pri),
					                $unsigned(head_priority))
					    + field_bad("is_empty", want.empty, is_empty)
					    + field_bad("entry_count", want.count, entry_count)
					    + field_bad("status", want.stat, status) != 0)
						fail_count++;
				end
			end
			if (in_valid && in_ready)
				expected_views.push_back(apply_request(func_t'(func), item_key, item_priority));
			pending = expected_views.size();
		end
	end

endmodule

// ===== bench/sorted_priority_queue_tb.sv =====
// Testbench top for the sorted priority queue: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict. Depends on spq_pkg, spq_checker
// and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int RANDOM_REQS = 1500;
	localparam int QUIET_TAIL  = 150;
	localparam int LONG_HOLD   = 120;
	localparam int STALL_LIMIT = 2000;
	localparam logic signed [PRI_BITS-1:0] PRI_MIN = 32'sh8000_0000;
	localparam logic signed [PRI_BITS-1:0] PRI_MAX = 32'sh7fff_ffff;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [1:0]                 func = FUNC_ENQ;
	logic [KEY_BITS-1:0]        item_key = '0;
	logic signed [PRI_BITS-1:0] item_priority = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [KEY_BITS-1:0]        taken_key;
	logic [KEY_BITS-1:0]        head_key;
	logic signed [PRI_BITS-1:0] head_priority;
	logic                       is_empty;
	logic [CNT_BITS-1:0]        entry_count;
	logic [1:0]                 status;

	int                         fail_count;
	int                         pending;
	int                         stall_cycles = 0;
	bit                         quiet = 1'b0;
	bit                         ready_gappy = 1'b1;
	bit                         long_hold_due = 1'b0;
	logic [KEY_BITS-1:0]        key_pool [24];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sorted_priority_queue dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .item_key(item_key), .item_priority(item_priority),
		.out_valid(out_valid), .out_ready(out_ready),
		.taken_key(taken_key), .head_key(head_key), .head_priority(head_priority),
		.is_empty(is_empty), .entry_count(entry_count), .status(status)
	);

	spq_checker result_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .item_key(item_key), .item_priority(item_priority),
		.out_valid(out_valid), .out_ready(out_ready),
		.taken_key(taken_key), .head_key(head_key), .head_priority(head_priority),
		.is_empty(is_empty), .entry_count(entry_count), .status(status),
		.fail_count(fail_count), .pending(pending)
	);

	task automatic send_request(input func_t f, input logic [KEY_BITS-1:0] k,
	                            input logic signed [PRI_BITS-1:0] p);
		@(negedge clk);
		in_valid      <= 1'b1;
		func          <= f;
		item_key      <= k;
		item_priority <= p;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic idle_sender(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, 23)];
		return $urandom;
	endfunction

	// mostly narrow priorities so ties are common
	function automatic logic signed [PRI_BITS-1:0] pick_priority();
		case ($urandom_range(0, 11))
			0, 1:    return $urandom;
			2:       return PRI_MIN;
			3:       return PRI_MAX;
			default: return $signed($urandom_range(0, 8)) - 4;
		endcase
	endfunction

	// mode 0 fills, mode 1 drains, mode 2 mixes
	function automatic func_t pick_func(input int mode);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return FUNC_CLEAR;
		if (r < 20)
			return FUNC_CHG;
		case (mode)
			0:       return r < 88 ? FUNC_ENQ : FUNC_DEQ;
			1:       return r < 38 ? FUNC_ENQ : FUNC_DEQ;
			default: return r < 60 ? FUNC_ENQ : FUNC_DEQ;
		endcase
	endfunction

	// result side back-pressure
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				out_ready <= 1'b1;
			end else if (!quiet && ready_gappy && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int  seg_left;
		int  mode;
		bit  sender_gappy;
		for (int i = 0; i < 24; i++)
			key_pool[i] = $urandom_range(0, 3) == 0 ? KEY_BITS'(i) : $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-queue cases, extremes, ties, full, change and clear
		send_request(FUNC_DEQ, 32'h0000_0001, 0);
		send_request(FUNC_CHG, 32'h0000_0005, 7);
		send_request(FUNC_ENQ, 32'h0000_0005, 10);
		send_request(FUNC_ENQ, 32'h0000_0005, 10);
		send_request(FUNC_ENQ, 32'h0000_0003, 10);
		send_request(FUNC_ENQ, 32'h0000_0000, PRI_MIN);
		send_request(FUNC_ENQ, 32'hffff_ffff, PRI_MAX);
		send_request(FUNC_ENQ, 32'h8000_0000, -1);
		for (int i = 0; i < 10; i++)
			send_request(FUNC_ENQ, 32'h5555_0000 + i, i[0] ? -2 : 10);
		send_request(FUNC_ENQ, 32'haaaa_aaaa, PRI_MIN);
		send_request(FUNC_CHG, 32'h0000_0000, 32'sd100);
		send_request(FUNC_CHG, 32'h0000_0077, 0);
		send_request(FUNC_CHG, 32'h0000_0005, -3);
		send_request(FUNC_DEQ, 32'hffff_ffff, PRI_MAX);
		send_request(FUNC_CLEAR, 32'h1234_5678, 0);
		send_request(FUNC_DEQ, 32'h0, 0);

		// random: segments of fill / drain / mixed traffic
		seg_left = 0;
		mode = 2;
		sender_gappy = 1'b1;
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (seg_left == 0) begin
				seg_left     = $urandom_range(8, 40);
				mode         = $urandom_range(0, 2);
				sender_gappy = $urandom_range(0, 2) != 0;
				ready_gappy  = $urandom_range(0, 2) != 0;
			end
			seg_left--;
			if (n == 400)
				long_hold_due = 1'b1;
			if (n == RANDOM_REQS - QUIET_TAIL)
				quiet = 1'b1;
			if (!quiet && sender_gappy && $urandom_range(0, 3) == 0)
				idle_sender($urandom_range(1, 12));
			send_request(pick_func(mode), pick_key(), pick_priority());
		end
		idle_sender(1);

		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
